// File: design/ppc_pkg.sv
// Shared constants and codes for the preset PD position controller.
package ppc_pkg;

	// Default configuration of the design parameters
	localparam int SENSOR_BITS_DEF    = 12;
	localparam int GAIN_FRAC_BITS_DEF = 8;

	// Fixed field widths
	localparam int GAIN_BITS   = 12;
	localparam int POWER_BITS  = 7;
	localparam int DRIVE_BITS  = 9;
	localparam int FUNC_BITS   = 2;
	localparam int PRESET_BITS = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	// Function codes of an input word
	localparam logic [FUNC_BITS-1:0] FUNC_TICK   = 2'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_PRESET = 2'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_TARGET = 2'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_MANUAL = 2'd3;

	// Preset codes
	localparam logic [PRESET_BITS-1:0] PRESET_UP     = 3'd0;
	localparam logic [PRESET_BITS-1:0] PRESET_HOLD   = 3'd1;
	localparam logic [PRESET_BITS-1:0] PRESET_DOWN   = 3'd2;
	localparam logic [PRESET_BITS-1:0] PRESET_KEEP   = 3'd6;
	localparam logic [PRESET_BITS-1:0] PRESET_RELOAD = 3'd7;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_POWER   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_P_GAIN      = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_D_GAIN      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_UP_TARGET   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TARGET = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_DOWN_TARGET = 3'd5;

	// Register reset values
	localparam logic [POWER_BITS-1:0] MAX_POWER_RST = 7'd100;
	localparam logic [GAIN_BITS-1:0]  P_GAIN_RST    = 12'd461;
	localparam logic [GAIN_BITS-1:0]  D_GAIN_RST    = 12'd205;
	localparam logic [31:0] UP_TARGET_RST   = 32'd580;
	localparam logic [31:0] HOLD_TARGET_RST = 32'd3000;
	localparam logic [31:0] DOWN_TARGET_RST = 32'd3900;

endpackage

// File: design/preset_pd_position_controller.sv
// Top level of the preset PD position controller: input stage, state, result register.
//
//  channel | signals                                               | direction
//  --------+-------------------------------------------------------+----------
//  input   | in_valid in_ready func sample preset_code target_value | in
//          | manual_on velocity                                    |
//  result  | out_valid out_ready drive is_velocity                 | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data                | in
//
// One word per cycle sustained while the result is not stalled; an accepted word
// passes the input register, then the result register. Each holds one word, so a
// new word is taken while a finished result waits; the whole PD law runs
// combinationally between them. Reset clears all control state and loads register
// defaults at once. A stalled result only blocks the stage behind it.
module preset_pd_position_controller #(
	parameter int SENSOR_BITS    = ppc_pkg::SENSOR_BITS_DEF,
	parameter int GAIN_FRAC_BITS = ppc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// input words
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [ppc_pkg::FUNC_BITS-1:0]          func,
	input  logic [SENSOR_BITS-1:0]                 sample,
	input  logic [ppc_pkg::PRESET_BITS-1:0]        preset_code,
	input  logic [SENSOR_BITS-1:0]                 target_value,
	input  logic                                   manual_on,
	input  logic signed [ppc_pkg::DRIVE_BITS-1:0]  velocity,
	// result words
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [ppc_pkg::DRIVE_BITS-1:0]  drive,
	output logic                                   is_velocity,
	// configuration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [ppc_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [ppc_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int PB = ppc_pkg::PRESET_BITS;
	localparam int OW = ppc_pkg::DRIVE_BITS;

	// configuration registers
	logic [ppc_pkg::POWER_BITS-1:0] max_power_q;
	logic [ppc_pkg::GAIN_BITS-1:0]  p_gain_q;
	logic [ppc_pkg::GAIN_BITS-1:0]  d_gain_q;
	logic [SENSOR_BITS-1:0]         up_target_q;
	logic [SENSOR_BITS-1:0]         hold_target_q;
	logic [SENSOR_BITS-1:0]         down_target_q;

	// controller state
	logic                           manual_q;
	logic                           captured_q;
	logic [PB-1:0]                  preset_now_q;
	logic [PB-1:0]                  preset_seen_q;
	logic [SENSOR_BITS-1:0]         target_q;
	logic signed [SENSOR_BITS:0]    last_error_q;

	// input stage
	logic                           valid_s1;
	logic [ppc_pkg::FUNC_BITS-1:0]  func_s1;
	logic [SENSOR_BITS-1:0]         sample_s1;
	logic [PB-1:0]                  code_s1;
	logic [SENSOR_BITS-1:0]         tval_s1;
	logic                           on_s1;
	logic signed [OW-1:0]           vel_s1;

	// result register
	logic                           out_valid_q;
	logic signed [OW-1:0]           drive_q;
	logic                           is_vel_q;

	logic                           fire_s1;
	logic                           in_fire;
	logic [PB-1:0]                  code_in;
	logic                           reload;
	logic [SENSOR_BITS-1:0]         target_eff;
	logic signed [SENSOR_BITS:0]    err;
	logic signed [OW-1:0]           power;

	// handshakes
	assign fire_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire_s1;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// code seven is a keep-position code
	assign code_in = (preset_code == ppc_pkg::PRESET_RELOAD) ? ppc_pkg::PRESET_KEEP
		: preset_code;

	// target reload on a changed preset, ahead of the PD law
	assign reload = (preset_now_q != preset_seen_q);
	always_comb begin
		target_eff = target_q;
		if (reload) begin
			case (preset_now_q)
				ppc_pkg::PRESET_UP:   target_eff = up_target_q;
				ppc_pkg::PRESET_HOLD: target_eff = hold_target_q;
				ppc_pkg::PRESET_DOWN: target_eff = down_target_q;
				default:              target_eff = target_q;
			endcase
		end
	end

	ppc_pd_law #(
		.SENSOR_BITS   (SENSOR_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_pd_law (
		.target    (target_eff),
		.sample    (sample_s1),
		.last_error(last_error_q),
		.p_gain    (p_gain_q),
		.d_gain    (d_gain_q),
		.max_power (max_power_q),
		.err       (err),
		.power     (power)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_power_q   <= ppc_pkg::MAX_POWER_RST;
			p_gain_q      <= ppc_pkg::P_GAIN_RST;
			d_gain_q      <= ppc_pkg::D_GAIN_RST;
			up_target_q   <= ppc_pkg::UP_TARGET_RST[SENSOR_BITS-1:0];
			hold_target_q <= ppc_pkg::HOLD_TARGET_RST[SENSOR_BITS-1:0];
			down_target_q <= ppc_pkg::DOWN_TARGET_RST[SENSOR_BITS-1:0];
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ppc_pkg::REG_MAX_POWER:   max_power_q <= cfg_data[ppc_pkg::POWER_BITS-1:0];
				ppc_pkg::REG_P_GAIN:      p_gain_q    <= cfg_data[ppc_pkg::GAIN_BITS-1:0];
				ppc_pkg::REG_D_GAIN:      d_gain_q    <= cfg_data[ppc_pkg::GAIN_BITS-1:0];
				ppc_pkg::REG_UP_TARGET:   up_target_q   <= cfg_data[SENSOR_BITS-1:0];
				ppc_pkg::REG_HOLD_TARGET: hold_target_q <= cfg_data[SENSOR_BITS-1:0];
				ppc_pkg::REG_DOWN_TARGET: down_target_q <= cfg_data[SENSOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_s1   <= func;
			sample_s1 <= sample;
			code_s1   <= code_in;
			tval_s1   <= target_value;
			on_s1     <= manual_on;
			vel_s1    <= velocity;
		end
	end

	// controller state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_q      <= 1'b0;
			captured_q    <= 1'b0;
			preset_now_q  <= ppc_pkg::PRESET_UP;
			preset_seen_q <= ppc_pkg::PRESET_UP;
			target_q      <= '0;
			last_error_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire_s1) begin
				unique case (func_s1)
					ppc_pkg::FUNC_TICK: begin
						if (manual_q) begin
							captured_q <= 1'b0;
						end else if (!captured_q) begin
							target_q   <= sample_s1;
							captured_q <= 1'b1;
						end else begin
							if (reload && preset_now_q != ppc_pkg::PRESET_UP
								&& preset_now_q != ppc_pkg::PRESET_HOLD
								&& preset_now_q != ppc_pkg::PRESET_DOWN) begin
								captured_q <= 1'b0;
							end
							target_q      <= target_eff;
							preset_seen_q <= preset_now_q;
							last_error_q  <= err;
							out_valid_q   <= 1'b1;
						end
					end
					ppc_pkg::FUNC_PRESET: begin
						preset_now_q  <= code_s1;
						preset_seen_q <= ppc_pkg::PRESET_RELOAD;
					end
					ppc_pkg::FUNC_TARGET: begin
						preset_seen_q <= preset_now_q;
						target_q      <= tval_s1;
					end
					ppc_pkg::FUNC_MANUAL: begin
						manual_q <= on_s1;
						if (on_s1) begin
							out_valid_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			if (func_s1 == ppc_pkg::FUNC_MANUAL) begin
				drive_q  <= vel_s1;
				is_vel_q <= 1'b1;
			end else begin
				drive_q  <= power;
				is_vel_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign drive       = drive_q;
	assign is_velocity = is_vel_q;

endmodule

// File: design/ppc_pd_law.sv
// PD control law: error, error difference, Q gains, truncation and symmetric clamp.
module ppc_pd_law #(
	parameter int SENSOR_BITS    = ppc_pkg::SENSOR_BITS_DEF,
	parameter int GAIN_FRAC_BITS = ppc_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic [SENSOR_BITS-1:0]                   target,
	input  logic [SENSOR_BITS-1:0]                   sample,
	input  logic signed [SENSOR_BITS:0]              last_error,
	input  logic [ppc_pkg::GAIN_BITS-1:0]            p_gain,
	input  logic [ppc_pkg::GAIN_BITS-1:0]            d_gain,
	input  logic [ppc_pkg::POWER_BITS-1:0]           max_power,
	output logic signed [SENSOR_BITS:0]              err,
	output logic signed [ppc_pkg::DRIVE_BITS-1:0]    power
);

	localparam int EW = SENSOR_BITS + 1;
	localparam int DW = SENSOR_BITS + 2;
	localparam int GW = ppc_pkg::GAIN_BITS + 1;
	localparam int SW = SENSOR_BITS + ppc_pkg::GAIN_BITS + 4;
	localparam int PW = ppc_pkg::POWER_BITS;
	localparam int OW = ppc_pkg::DRIVE_BITS;

	logic signed [DW-1:0]    derr;
	logic signed [GW+EW-1:0] p_term;
	logic signed [GW+DW-1:0] d_term;
	logic signed [SW-1:0]    sum;
	logic [SW-1:0]           mag;
	logic [SW-1:0]           mag_q;
	logic [SW-1:0]           lim_ext;
	logic [PW-1:0]           lim_mag;
	logic signed [OW-1:0]    lim_out;

	// error and its change since the last PD tick
	assign err  = $signed({1'b0, target}) - $signed({1'b0, sample});
	assign derr = $signed({err[EW-1], err}) - $signed({last_error[EW-1], last_error});

	// gain products, exact sum with fractional bits
	assign p_term = $signed({1'b0, p_gain}) * err;
	assign d_term = $signed({1'b0, d_gain}) * derr;
	assign sum    = SW'(p_term) + SW'(d_term);

	// truncate toward zero on the magnitude
	assign mag   = sum[SW-1] ? SW'(-sum) : SW'(sum);
	assign mag_q = mag >> GAIN_FRAC_BITS;

	// symmetric clamp, then restore the sign
	assign lim_ext = {{(SW-PW){1'b0}}, max_power};
	assign lim_mag = (mag_q > lim_ext) ? max_power : mag_q[PW-1:0];
	assign lim_out = $signed({{(OW-PW){1'b0}}, lim_mag});
	assign power   = sum[SW-1] ? -lim_out : lim_out;

endmodule
